/* design/lrbc_pkg.sv */
`timescale 1ns / 1ps

package lrbc_pkg;

  localparam int TIME_BITS = 48;
  localparam int CFG_W     = 24;
  localparam int CNT_W     = 8;
  localparam int BUDGET_W  = 8;
  localparam int WAIT_W    = 25;
  localparam int RND_W     = 32;
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 2;

  // Division by five through a reciprocal: floor(x / 5) = (x * 0xCCCCCCCD) >> 34
  // holds for every x below 2^32.
  localparam logic [31:0] DIV5_MAGIC = 32'hCCCCCCCD;
  localparam int          DIV5_SHIFT = 34;
  localparam int          PROD_W     = CFG_W + 32;
  localparam int          JIT_W      = CFG_W - 2;   // max / 5 stays below 2^22
  localparam int          SPAN_W     = JIT_W + 1;
  localparam int          MOD_CNT_W  = $clog2(RND_W);

  localparam logic [CMD_W-1:0] CMD_START      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINK_UP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADDR_ACQ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

  localparam logic [IDX_W-1:0] REG_RETRY_BASE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RETRY_MAX   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CONN_TMO    = 2'd2;
  localparam logic [IDX_W-1:0] REG_RETRY_BUDGET = 2'd3;

  localparam logic [CFG_W-1:0]    RST_RETRY_BASE   = 24'd1000;
  localparam logic [CFG_W-1:0]    RST_RETRY_MAX    = 24'd60000;
  localparam logic [CFG_W-1:0]    RST_CONN_TMO     = 24'd15000;
  localparam logic [BUDGET_W-1:0] RST_RETRY_BUDGET = 8'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DBL,
    ST_MUL,
    ST_SPAN,
    ST_MOD,
    ST_WAIT,
    ST_SET,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic dbl;
    logic mul;
    logic span;
    logic mod_step;
    logic wait_sum;
    logic set_time;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic need_wait;
    logic dbl_done;
    logic mod_done;
  } sts_t;

endpackage

/* design/lrbc_if.sv */
`timescale 1ns / 1ps

interface lrbc_evt_if;
  logic                          valid;
  logic                          ready;
  logic [lrbc_pkg::CMD_W-1:0]     cmd;
  logic [lrbc_pkg::TIME_BITS-1:0] now_ms;
  logic                          connect_ok;
  logic [lrbc_pkg::RND_W-1:0]     random_word;

  modport source(output valid, cmd, now_ms, connect_ok, random_word, input ready);
  modport sink(input valid, cmd, now_ms, connect_ok, random_word, output ready);
endinterface

interface lrbc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        issue_connect;
  logic                        issue_disconnect;
  logic                        connected;
  logic                        bootstrap_failed;
  logic [lrbc_pkg::CNT_W-1:0]  retry_total;
  logic [lrbc_pkg::WAIT_W-1:0] scheduled_wait_ms;

  modport source(output valid, issue_connect, issue_disconnect, connected,
                 bootstrap_failed, retry_total, scheduled_wait_ms, input ready);
  modport sink(input valid, issue_connect, issue_disconnect, connected,
               bootstrap_failed, retry_total, scheduled_wait_ms, output ready);
endinterface

/* design/link_reconnect_backoff_controller.sv */
`timescale 1ns / 1ps

// Reconnect controller with exponential backoff and jitter.
// Events enter on the evt channel (start, link up, disconnected, address acquired,
// tick with the current millisecond time) and each produces exactly one status
// transaction on the res channel. Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while no event is in flight, since
// the block itself does not enforce this. One event is processed at a time. An
// event that schedules no retry passes through EVAL and DONE; an event that
// schedules a retry also passes through DBL (at most 24 doublings of the base
// wait), MUL, SPAN, the 32-step remainder loop that draws the jitter, WAIT and SET.
// Reset clears all link state and loads the default register values; evt.ready
// is high in the first cycle after reset.
// The finished status sits in an output register. While the receiver stalls, the
// next event is still accepted and processed, and its result is held until the
// output register is taken.
module link_reconnect_backoff_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lrbc_pkg::IDX_W-1:0] cfg_index,
  input  logic [lrbc_pkg::CFG_W-1:0] cfg_data,
  lrbc_evt_if.sink                   evt,
  lrbc_res_if.source                 res
);

  lrbc_pkg::ctl_t ctl;
  lrbc_pkg::sts_t sts;

  lrbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lrbc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .evt_cmd           (evt.cmd),
    .evt_now_ms        (evt.now_ms),
    .evt_connect_ok    (evt.connect_ok),
    .evt_random_word   (evt.random_word),
    .ctl               (ctl),
    .sts               (sts),
    .issue_connect     (res.issue_connect),
    .issue_disconnect  (res.issue_disconnect),
    .connected         (res.connected),
    .bootstrap_failed  (res.bootstrap_failed),
    .retry_total       (res.retry_total),
    .scheduled_wait_ms (res.scheduled_wait_ms)
  );

endmodule

/* design/lrbc_ctrl.sv */
`timescale 1ns / 1ps

module lrbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  lrbc_pkg::sts_t sts,
  output lrbc_pkg::ctl_t ctl
);

  lrbc_pkg::state_t state, state_next;
  logic             out_free;

  assign out_free  = !res_valid || res_ready;
  assign evt_ready = (state == lrbc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrbc_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      lrbc_pkg::ST_IDLE: begin
        if (evt_valid) begin
          ctl.load   = 1'b1;
          state_next = lrbc_pkg::ST_EVAL;
        end
      end
      lrbc_pkg::ST_EVAL: begin
        ctl.eval   = 1'b1;
        state_next = sts.need_wait ? lrbc_pkg::ST_DBL : lrbc_pkg::ST_DONE;
      end
      lrbc_pkg::ST_DBL: begin
        ctl.dbl = 1'b1;
        if (sts.dbl_done) begin
          state_next = lrbc_pkg::ST_MUL;
        end
      end
      lrbc_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = lrbc_pkg::ST_SPAN;
      end
      lrbc_pkg::ST_SPAN: begin
        ctl.span   = 1'b1;
        state_next = lrbc_pkg::ST_MOD;
      end
      lrbc_pkg::ST_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = lrbc_pkg::ST_WAIT;
        end
      end
      lrbc_pkg::ST_WAIT: begin
        ctl.wait_sum = 1'b1;
        state_next   = lrbc_pkg::ST_SET;
      end
      lrbc_pkg::ST_SET: begin
        ctl.set_time = 1'b1;
        state_next   = lrbc_pkg::ST_DONE;
      end
      lrbc_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = lrbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/lrbc_datapath.sv */
`timescale 1ns / 1ps

module lrbc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrbc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lrbc_pkg::CFG_W-1:0]     cfg_data,
  input  logic [lrbc_pkg::CMD_W-1:0]     evt_cmd,
  input  logic [lrbc_pkg::TIME_BITS-1:0] evt_now_ms,
  input  logic                           evt_connect_ok,
  input  logic [lrbc_pkg::RND_W-1:0]     evt_random_word,
  input  lrbc_pkg::ctl_t                 ctl,
  output lrbc_pkg::sts_t                 sts,
  output logic                           issue_connect,
  output logic                           issue_disconnect,
  output logic                           connected,
  output logic                           bootstrap_failed,
  output logic [lrbc_pkg::CNT_W-1:0]     retry_total,
  output logic [lrbc_pkg::WAIT_W-1:0]    scheduled_wait_ms
);

  // Configuration
  logic [lrbc_pkg::CFG_W-1:0]    retry_base;
  logic [lrbc_pkg::CFG_W-1:0]    retry_max;
  logic [lrbc_pkg::CFG_W-1:0]    conn_tmo;
  logic [lrbc_pkg::BUDGET_W-1:0] retry_budget;

  // Captured event
  logic [lrbc_pkg::CMD_W-1:0]     cmd_q;
  logic [lrbc_pkg::TIME_BITS-1:0] now_q;
  logic                           ok_q;
  logic [lrbc_pkg::RND_W-1:0]     rnd_q;

  // Link state
  logic                           started;
  logic                           scheduled;
  logic                           in_progress;
  logic                           failed;
  logic                           link_up;
  logic [lrbc_pkg::CNT_W-1:0]     retry_cnt;
  logic [lrbc_pkg::TIME_BITS-1:0] next_retry_at;
  logic [lrbc_pkg::TIME_BITS-1:0] attempt_at;

  // Per-transaction result and backoff working registers
  logic                            ic_q;
  logic                            idc_q;
  logic [lrbc_pkg::WAIT_W-1:0]     wait_q;
  logic [lrbc_pkg::WAIT_W-1:0]     backoff;
  logic [lrbc_pkg::CNT_W-1:0]      dbl_idx;
  logic [lrbc_pkg::CNT_W-1:0]      dbl_limit;
  logic [lrbc_pkg::PROD_W-1:0]     prod;
  logic [lrbc_pkg::JIT_W-1:0]      jitter;
  logic [lrbc_pkg::SPAN_W-1:0]     rem;
  logic [lrbc_pkg::RND_W-1:0]      quo;
  logic [lrbc_pkg::MOD_CNT_W-1:0]  mod_cnt;

  logic                           active;
  logic                           timed_out;
  logic                           due;
  logic                           tick_connect;
  logic                           tick_timeout;
  logic                           sched;
  logic                           spent;
  logic [lrbc_pkg::CNT_W-1:0]     cnt_bumped;
  logic [lrbc_pkg::CNT_W-1:0]     cnt_new;
  logic [lrbc_pkg::TIME_BITS-1:0] elapsed;
  logic                           dbl_go;
  logic [lrbc_pkg::WAIT_W-1:0]    max_ext;
  logic [lrbc_pkg::SPAN_W-1:0]    span;
  logic [lrbc_pkg::SPAN_W:0]      trial;
  logic                           trial_ge;

  always_comb begin
    active       = started && !failed && !link_up;
    elapsed      = now_q - attempt_at;
    timed_out    = elapsed >= lrbc_pkg::TIME_BITS'(conn_tmo);
    due          = now_q >= next_retry_at;
    tick_timeout = (cmd_q == lrbc_pkg::CMD_TICK) && active && in_progress && timed_out;
    tick_connect = (cmd_q == lrbc_pkg::CMD_TICK) && active && !in_progress &&
                   scheduled && due;
    cnt_bumped   = (retry_cnt == '1) ? retry_cnt : retry_cnt + 1'b1;
    if ((cmd_q == lrbc_pkg::CMD_LINK_UP) || (cmd_q == lrbc_pkg::CMD_ADDR_ACQ)) begin
      cnt_new = '0;
    end else if (tick_connect) begin
      cnt_new = cnt_bumped;
    end else begin
      cnt_new = retry_cnt;
    end
    sched = (cmd_q == lrbc_pkg::CMD_DISCONNECT) || tick_timeout || (tick_connect && !ok_q);
    spent = cnt_new >= retry_budget;
    sts.need_wait = sched && !spent;

    // A zero wait never grows, so doubling stops there.
    max_ext      = lrbc_pkg::WAIT_W'(retry_max);
    dbl_go       = (dbl_idx < dbl_limit) && (backoff < max_ext) && (backoff != '0);
    sts.dbl_done = !dbl_go;

    span         = {jitter, 1'b1};
    trial        = {rem, quo[lrbc_pkg::RND_W-1]};
    trial_ge     = trial >= {1'b0, span};
    sts.mod_done = mod_cnt == lrbc_pkg::MOD_CNT_W'(lrbc_pkg::RND_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_base   <= lrbc_pkg::RST_RETRY_BASE;
      retry_max    <= lrbc_pkg::RST_RETRY_MAX;
      conn_tmo     <= lrbc_pkg::RST_CONN_TMO;
      retry_budget <= lrbc_pkg::RST_RETRY_BUDGET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrbc_pkg::REG_RETRY_BASE:   retry_base   <= cfg_data;
        lrbc_pkg::REG_RETRY_MAX:    retry_max    <= cfg_data;
        lrbc_pkg::REG_CONN_TMO:     conn_tmo     <= cfg_data;
        lrbc_pkg::REG_RETRY_BUDGET: retry_budget <= cfg_data[lrbc_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      scheduled     <= 1'b0;
      in_progress   <= 1'b0;
      failed        <= 1'b0;
      link_up       <= 1'b0;
      retry_cnt     <= '0;
      next_retry_at <= '0;
      attempt_at    <= '0;
    end else if (ctl.eval) begin
      case (cmd_q)
        lrbc_pkg::CMD_START: begin
          started <= 1'b1;
          failed  <= 1'b0;
        end
        lrbc_pkg::CMD_LINK_UP: begin
          next_retry_at <= '0;
          scheduled     <= 1'b1;
          in_progress   <= 1'b0;
          failed        <= 1'b0;
        end
        lrbc_pkg::CMD_DISCONNECT: begin
          link_up <= 1'b0;
        end
        lrbc_pkg::CMD_ADDR_ACQ: begin
          scheduled   <= 1'b0;
          in_progress <= 1'b0;
          link_up     <= 1'b1;
        end
        lrbc_pkg::CMD_TICK: begin
          if (tick_connect && ok_q) begin
            scheduled   <= 1'b0;
            in_progress <= 1'b1;
            attempt_at  <= now_q;
          end
        end
        default: ;
      endcase
      retry_cnt <= cnt_new;
      // A retry either fails the bootstrap or arms the schedule; the time is set later.
      if (sched) begin
        in_progress <= 1'b0;
        scheduled   <= !spent;
        if (spent) begin
          failed <= 1'b1;
        end
      end
    end else if (ctl.set_time) begin
      next_retry_at <= now_q + lrbc_pkg::TIME_BITS'(wait_q);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= evt_cmd;
      now_q <= evt_now_ms;
      ok_q  <= evt_connect_ok;
      rnd_q <= evt_random_word;
    end
    if (ctl.eval) begin
      ic_q      <= tick_connect;
      idc_q     <= tick_timeout;
      wait_q    <= '0;
      backoff   <= lrbc_pkg::WAIT_W'(retry_base);
      dbl_idx   <= '0;
      dbl_limit <= cnt_new;
    end
    if (ctl.dbl) begin
      if (dbl_go) begin
        backoff <= {backoff[lrbc_pkg::WAIT_W-2:0], 1'b0};
        dbl_idx <= dbl_idx + 1'b1;
      end else if (backoff > max_ext) begin
        backoff <= max_ext;
      end
    end
    if (ctl.mul) begin
      prod <= backoff[lrbc_pkg::CFG_W-1:0] * lrbc_pkg::DIV5_MAGIC;
    end
    if (ctl.span) begin
      jitter  <= prod[lrbc_pkg::PROD_W-1:lrbc_pkg::DIV5_SHIFT];
      rem     <= '0;
      quo     <= rnd_q;
      mod_cnt <= '0;
    end
    if (ctl.mod_step) begin
      rem     <= trial_ge ? lrbc_pkg::SPAN_W'(trial - {1'b0, span})
                          : trial[lrbc_pkg::SPAN_W-1:0];
      quo     <= {quo[lrbc_pkg::RND_W-2:0], 1'b0};
      mod_cnt <= mod_cnt + 1'b1;
    end
    if (ctl.wait_sum) begin
      wait_q <= backoff - lrbc_pkg::WAIT_W'(jitter) + lrbc_pkg::WAIT_W'(rem);
    end
    if (ctl.emit) begin
      issue_connect     <= ic_q;
      issue_disconnect  <= idc_q;
      connected         <= link_up;
      bootstrap_failed  <= failed;
      retry_total       <= retry_cnt;
      scheduled_wait_ms <= wait_q;
    end
  end

endmodule

/* design/lrbc_checker.sv */
`timescale 1ns / 1ps

module lrbc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       evt_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       issue_connect,
  input logic                       issue_disconnect,
  input logic                       connected,
  input logic [lrbc_pkg::CNT_W-1:0] retry_total
);

  // A tick either times out an attempt or issues a connect, never both.
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(issue_connect && issue_disconnect))
    else $error("connect and disconnect issued in one transaction");

  // Connect and timeout only happen while the link is down.
  a_not_connected: assert property (@(posedge clk) disable iff (rst)
    res_valid && (issue_connect || issue_disconnect) |-> !connected)
    else $error("connect activity reported while connected");

  // An issued connect always counts as an attempt.
  a_connect_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && issue_connect |-> retry_total != '0)
    else $error("issued connect left the retry count at zero");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> evt_ready)
    else $error("event channel not ready after reset");

endmodule

bind link_reconnect_backoff_controller lrbc_checker u_lrbc_checker (
  .clk              (clk),
  .rst              (rst),
  .evt_ready        (evt.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .issue_connect    (res.issue_connect),
  .issue_disconnect (res.issue_disconnect),
  .connected        (res.connected),
  .retry_total      (res.retry_total)
);
